### rtl/core/srpq_pkg.sv
// Shared types and constants of the sorted ring priority queue.
package srpq_pkg;

	localparam int PRIO_W = 8;
	localparam int INFO_W = 8;
	localparam int CNT_W  = 5;

	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [INFO_W-1:0] info;
	} entry_t;

endpackage

### rtl/core/srpq_if.sv
// Command and result channel interfaces of the sorted ring priority queue.
interface srpq_cmd_if import srpq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [PRIO_W-1:0] new_prio;
	logic [INFO_W-1:0] new_info;

	modport source (output valid, mode, new_prio, new_info, input ready);
	modport sink (input valid, mode, new_prio, new_info, output ready);
endinterface

interface srpq_res_if import srpq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [PRIO_W-1:0] out_prio;
	logic [INFO_W-1:0] out_info;
	logic [CNT_W-1:0]  entry_count;
	logic              is_empty;
	logic              is_full;

	modport source (output valid, status, out_prio, out_info, entry_count, is_empty, is_full,
		input ready);
	modport sink (input valid, status, out_prio, out_info, entry_count, is_empty, is_full,
		output ready);
endinterface

### rtl/core/srpq_store.sv
// Entry store: one write port, one read port with registered read data.
module srpq_store import srpq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  entry_t                   wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output entry_t                   rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/sorted_ring_priority_queue.sv
// Sorted ring priority queue: top level with sequencer and configuration port.
// Sequence: a refused item or an enqueue into an empty queue goes straight to S_OUT, a dequeue
// passes S_DEQ, any other enqueue stays in S_INS while it passes entries; output stalls hold S_OUT.
// A new item is accepted only in S_IDLE, after the last result is registered; the insertion walk
// moves one entry per cycle through the single write port of the entry store.
// Reset: queue empty, capacity 16, indices 0; store contents are undefined, no clearing pass.
module sorted_ring_priority_queue import srpq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	srpq_cmd_if.sink    cmd,
	srpq_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = $clog2(DEPTH);
	localparam int PW = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS,
		S_DEQ,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [IW-1:0]     head_q;
	logic [IW-1:0]     tail_q;
	logic [IW-1:0]     a1_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_q;
	entry_t            ent_q;
	logic [1:0]        rstat_q;
	entry_t            rent_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	entry_t            out_ent_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_empty_q;
	logic              out_full_q;

	logic [CNT_W-1:0]  cap_eff;
	logic [PW-1:0]     capw;
	logic [IW-1:0]     a2;
	logic              cfg_wr;
	logic              accept;
	logic              shift;
	logic              we;
	logic [IW-1:0]     waddr;
	entry_t            wdata;
	logic [IW-1:0]     raddr;
	entry_t            rdata;

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x, input logic [PW-1:0] c);
		logic [PW-1:0] nx;
		nx = PW'(x) + PW'(1);
		return (nx == c) ? '0 : IW'(nx);
	endfunction

	function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x, input logic [PW-1:0] c);
		return (x == '0) ? IW'(c - PW'(1)) : x - IW'(1);
	endfunction

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(cap_q) > 32'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign capw   = PW'(cap_eff);
	assign a2     = idx_dec(a1_q, capw);
	assign cfg_wr = psel && penable && pwrite;
	assign accept = cmd.valid && (state_q == S_IDLE);
	assign shift  = (a1_q != head_q) && (ent_q.prio < rdata.prio);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : '0;

	assign cmd.ready       = (state_q == S_IDLE);
	assign res.valid       = out_valid_q;
	assign res.status      = out_status_q;
	assign res.out_prio    = out_ent_q.prio;
	assign res.out_info    = out_ent_q.info;
	assign res.entry_count = out_count_q;
	assign res.is_empty    = out_empty_q;
	assign res.is_full     = out_full_q;

	always_comb begin
		we    = 1'b0;
		waddr = a1_q;
		wdata = ent_q;
		raddr = head_q;
		case (state_q)
			S_IDLE: begin
				raddr = (cmd.mode == MODE_ENQ) ? tail_q : head_q;
				if (accept && cmd.mode == MODE_ENQ && count_q == '0) begin
					we         = 1'b1;
					waddr      = '0;
					wdata.prio = cmd.new_prio;
					wdata.info = cmd.new_info;
				end
			end
			S_INS: begin
				we    = 1'b1;
				raddr = idx_dec(a2, capw);
				if (shift) begin
					wdata = rdata;
				end
			end
			default: begin
			end
		endcase
	end

	srpq_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			cap_q        <= CAP_RESET;
			out_valid_q  <= 1'b0;
			a1_q         <= '0;
			ent_q        <= '0;
			rstat_q      <= ST_DONE;
			rent_q       <= '0;
			out_status_q <= ST_DONE;
			out_ent_q    <= '0;
			out_count_q  <= '0;
			out_empty_q  <= 1'b1;
			out_full_q   <= 1'b0;
		end else begin
			if (res.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr && paddr[2] == REG_CAPACITY) begin
				cap_q   <= pwdata[CNT_W-1:0];
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rent_q     <= '0;
						ent_q.prio <= cmd.new_prio;
						ent_q.info <= cmd.new_info;
						if (cmd.mode == MODE_ENQ) begin
							if (count_q == cap_eff) begin
								rstat_q <= ST_FULL;
								state_q <= S_OUT;
							end else if (count_q == '0) begin
								rstat_q <= ST_DONE;
								head_q  <= '0;
								tail_q  <= '0;
								count_q <= CNT_W'(1);
								state_q <= S_OUT;
							end else begin
								rstat_q <= ST_DONE;
								tail_q  <= idx_inc(tail_q, capw);
								a1_q    <= idx_inc(tail_q, capw);
								count_q <= count_q + CNT_W'(1);
								state_q <= S_INS;
							end
						end else begin
							if (count_q == '0) begin
								rstat_q <= ST_EMPTY;
								state_q <= S_OUT;
							end else begin
								rstat_q <= ST_DONE;
								state_q <= S_DEQ;
							end
						end
					end
				end
				S_INS: begin
					if (shift) begin
						a1_q <= a2;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DEQ: begin
					rent_q <= rdata;
					if (count_q == CNT_W'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						head_q <= idx_inc(head_q, capw);
					end
					count_q <= count_q - CNT_W'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= rstat_q;
						out_ent_q    <= rent_q;
						out_count_q  <= count_q;
						out_empty_q  <= (count_q == '0);
						out_full_q   <= (count_q == cap_eff);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### dv/srpq_checker.sv
// Checker for the sorted ring priority queue: predicts each item's result and compares.
module srpq_checker import srpq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	srpq_cmd_if         cmd,
	srpq_res_if         res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

	typedef struct packed {
		logic [1:0]        status;
		logic [PRIO_W-1:0] prio;
		logic [INFO_W-1:0] info;
		logic [CNT_W-1:0]  count;
		logic              empty;
		logic              full;
	} outcome_t;

	entry_t           ring [DEPTH];
	int unsigned      head;
	int unsigned      tail;
	bit               q_empty;
	logic [CNT_W-1:0] cap_reg;
	outcome_t         pending_outcomes [$];

	function automatic int unsigned slots_in_use();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > DEPTH)
			return DEPTH;
		return cap_reg;
	endfunction

	function automatic int unsigned entries_held();
		if (q_empty)
			return 0;
		if (tail >= head)
			return tail - head + 1;
		return slots_in_use() + tail - head + 1;
	endfunction

	function automatic outcome_t service_command(logic m, logic [PRIO_W-1:0] p,
		logic [INFO_W-1:0] v);
		outcome_t    o;
		int unsigned c;
		int unsigned a1;
		int unsigned a2;
		entry_t      t;
		c = slots_in_use();
		o = '0;
		o.status = ST_DONE;
		if (m == MODE_ENQ) begin
			if (entries_held() == c) begin
				o.status = ST_FULL;
			end else begin
				if (q_empty) begin
					head = 0;
					tail = 0;
					q_empty = 1'b0;
				end else begin
					tail = (tail + 1) % c;
				end
				ring[tail] = {p, v};
				a1 = tail;
				a2 = (a1 + c - 1) % c;
				// bubble toward the head; ties keep arrival order
				while (a1 != head && ring[a1].prio < ring[a2].prio) begin
					t = ring[a1];
					ring[a1] = ring[a2];
					ring[a2] = t;
					a1 = a2;
					a2 = (a1 + c - 1) % c;
				end
			end
		end else begin
			if (q_empty) begin
				o.status = ST_EMPTY;
			end else begin
				o.prio = ring[head].prio;
				o.info = ring[head].info;
				if (entries_held() == 1) begin
					head = 0;
					tail = 0;
					q_empty = 1'b1;
				end else begin
					head = (head + 1) % c;
				end
			end
		end
		o.count = CNT_W'(entries_held());
		o.empty = (entries_held() == 0);
		o.full = (entries_held() == c);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_o;
		outcome_t got_o;
		if (!arst_n) begin
			head = 0;
			tail = 0;
			q_empty = 1'b1;
			cap_reg = CAP_RESET;
			errors = 0;
			pending_outcomes.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
				cap_reg = pwdata[CNT_W-1:0];
				head = 0;
				tail = 0;
				q_empty = 1'b1;
			end
			if (res.valid && res.ready) begin
				got_o = {res.status, res.out_prio, res.out_info, res.entry_count,
					res.is_empty, res.is_full};
				if (pending_outcomes.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%t: unexpected item on result channel: %h", $realtime, got_o);
				end else begin
					exp_o = pending_outcomes.pop_front();
					if (got_o.status !== exp_o.status || got_o.prio !== exp_o.prio ||
						got_o.info !== exp_o.info || got_o.count !== exp_o.count ||
						got_o.empty !== exp_o.empty || got_o.full !== exp_o.full) begin
						errors++;
						if (errors <= 10)
							$display({"%t: mismatch exp status=%0d prio=%0d info=%0d count=%0d ",
								"empty=%0b full=%0b got status=%0d prio=%0d info=%0d count=%0d ",
								"empty=%0b full=%0b"}, $realtime,
								exp_o.status, exp_o.prio, exp_o.info, exp_o.count,
								exp_o.empty, exp_o.full,
								got_o.status, got_o.prio, got_o.info, got_o.count,
								got_o.empty, got_o.full);
					end
				end
			end
			if (cmd.valid && cmd.ready)
				pending_outcomes.push_back(service_command(cmd.mode, cmd.new_prio, cmd.new_info));
		end
		pending = pending_outcomes.size();
	end

endmodule

### dv/tb.sv
// Testbench top for the sorted ring priority queue: stimulus, idling and verdict.
module tb import srpq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         DEPTH       = 16;
	localparam logic [2:0] CAP_ADDR    = {REG_CAPACITY, 2'b00};
	localparam int         HOLD_CYCLES = 200;
	localparam int         IDLE_LIMIT  = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        steady;
	logic        hold_off;
	int          chk_errors;
	int          chk_pending;

	srpq_cmd_if cmd_ch ();
	srpq_res_if res_ch ();

	sorted_ring_priority_queue #(.DEPTH(DEPTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	srpq_checker #(.DEPTH(DEPTH)) checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.errors  (chk_errors),
		.pending (chk_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send_item(logic m, logic [PRIO_W-1:0] p, logic [INFO_W-1:0] v);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 8) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= m;
		cmd_ch.new_prio <= p;
		cmd_ch.new_info <= v;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
	endtask

	task automatic take_head();
		send_item(MODE_DEQ, PRIO_W'($urandom), INFO_W'($urandom));
	endtask

	task automatic settle(int tail_cycles);
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		wait (chk_pending == 0);
		repeat (tail_cycles) @(negedge clk);
	endtask

	task automatic write_capacity(logic [CNT_W-1:0] cap);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= {{(32-CNT_W){1'b0}}, cap};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [PRIO_W-1:0] pick_prio();
		case ($urandom_range(3))
			0:       return PRIO_W'($urandom_range(3));
			1:       return $urandom_range(1) ? {PRIO_W{1'b1}} : '0;
			default: return PRIO_W'($urandom_range(255));
		endcase
	endfunction

	task automatic run_random(int n, bit with_hold);
		int burst;
		int enq_pct;
		burst = 0;
		enq_pct = 50;
		for (int k = 0; k < n; k++) begin
			if (burst == 0) begin
				burst = $urandom_range(40, 12);
				enq_pct = $urandom_range(1) ? 75 : 30;
			end
			burst--;
			if (with_hold && k == n / 2)
				hold_off = 1'b1;
			send_item(($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ, pick_prio(),
				INFO_W'($urandom_range(255)));
		end
	endtask

	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
			res_ch.ready <= steady || ($urandom_range(99) >= 8);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [CNT_W-1:0] caps [10];
		caps = '{5'd16, 5'd31, 5'd1, 5'd4, 5'd16, 5'd7, 5'd2, 5'd12, 5'd3, 5'd16};
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_ENQ;
		cmd_ch.new_prio = '0;
		cmd_ch.new_info = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 1'b0;
		hold_off = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// capacity after reset: empty refusal, extremes, ties, drain past empty
		take_head();
		send_item(MODE_ENQ, 8'hFF, 8'hFF);
		send_item(MODE_ENQ, 8'h00, 8'h00);
		send_item(MODE_ENQ, 8'h80, 8'hAA);
		send_item(MODE_ENQ, 8'h80, 8'h55);
		send_item(MODE_ENQ, 8'h01, 8'h01);
		repeat (6) take_head();
		settle(4);

		// two slots: full refusal and wrap of the ring
		write_capacity(5'd2);
		send_item(MODE_ENQ, 8'd9, 8'h10);
		send_item(MODE_ENQ, 8'd3, 8'h20);
		send_item(MODE_ENQ, 8'd7, 8'h30);
		take_head();
		send_item(MODE_ENQ, 8'd200, 8'h40);
		repeat (3) take_head();
		settle(4);

		// zero acts as one slot
		write_capacity(5'd0);
		send_item(MODE_ENQ, 8'h5A, 8'hA5);
		send_item(MODE_ENQ, 8'h00, 8'h00);
		take_head();
		settle(4);

		for (int ph = 0; ph < 10; ph++) begin
			write_capacity(caps[ph]);
			steady = (ph == 3);
			run_random(120, ph == 0);
			settle(4);
		end
		steady = 1'b0;
		settle(DEPTH + 4);

		if (chk_errors == 0 && chk_pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
